// ===== src/multichannel_bit_error_counter_macros.svh =====
// Assertion macros shared by the bit error counter modules.
`ifndef MULTICHANNEL_BIT_ERROR_COUNTER_MACROS_SVH
`define MULTICHANNEL_BIT_ERROR_COUNTER_MACROS_SVH

`ifndef ASSERT_OFF
`define MBEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MBEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MBEC_ASSERT(lbl, prop, msg)
`define MBEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/mbec_pkg.sv =====
// Shared types and constants of the multichannel bit error counter.
`timescale 1ns / 1ps
`default_nettype none
package mbec_pkg;

  localparam int unsigned DEF_CHANNELS = 16;

  localparam int unsigned CH_W   = 4;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ADD_W  = 4;
  localparam int unsigned ERR_W  = 32;
  localparam int unsigned CNT_W  = 48;
  localparam int unsigned LIM_W  = 48;
  localparam int unsigned CFG_W  = 48;
  localparam int unsigned REG_W  = 1;
  localparam int unsigned ST_W   = 2;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  localparam logic [REG_W-1:0] REG_MIN_ERRORS = 1'd0;
  localparam logic [REG_W-1:0] REG_BIT_LIMIT  = 1'd1;

  localparam logic [ERR_W-1:0] MIN_ERRORS_RST = 32'd100;
  localparam logic [LIM_W-1:0] BIT_LIMIT_RST  = 48'd100000000;
  localparam logic [ERR_W-1:0] ERR_RST        = 32'd1;
  localparam logic [ERR_W-1:0] ERR_MAX        = {ERR_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};

  localparam logic [ST_W-1:0] ST_COUNTED = 2'd0;
  localparam logic [ST_W-1:0] ST_ENOUGH  = 2'd1;
  localparam logic [ST_W-1:0] ST_LIMIT   = 2'd2;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             inrange;
    logic [ADD_W-1:0] add;
  } item_t;

endpackage
`default_nettype wire

// ===== src/mbec_front.sv =====
// Front end: accepts items, counts differing bits, queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_bit_error_counter_macros.svh"
module mbec_front #(
  parameter int unsigned CHANNELS = mbec_pkg::DEF_CHANNELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mbec_pkg::CH_W-1:0]   channel,
  input  wire logic [mbec_pkg::BYTE_W-1:0] ref_byte,
  input  wire logic [mbec_pkg::BYTE_W-1:0] rx_byte,
  output logic                             q_valid,
  output mbec_pkg::item_t                  q_item,
  input  wire logic                        q_pop
);

  mbec_pkg::item_t                 qmem [mbec_pkg::QDEPTH];
  logic [mbec_pkg::QPTR_W-1:0]     wr_ptr;
  logic [mbec_pkg::QPTR_W-1:0]     rd_ptr;
  logic [mbec_pkg::QPTR_W:0]       count;
  logic [mbec_pkg::BYTE_W-1:0]     diff;
  logic [mbec_pkg::ADD_W-1:0]      ones;
  mbec_pkg::item_t                 cls;
  logic                            push;
  logic                            pop;

  assign diff = ref_byte ^ rx_byte;

  always_comb begin
    ones = '0;
    for (int i = 0; i < mbec_pkg::BYTE_W; i++) begin
      ones = ones + mbec_pkg::ADD_W'(diff[i]);
    end
  end

  always_comb begin
    cls.ch      = channel;
    cls.inrange = (32'(channel) < CHANNELS);
    cls.add     = ones;
  end

  assign in_ready = (count != (mbec_pkg::QPTR_W+1)'(mbec_pkg::QDEPTH));
  assign q_valid  = (count != '0);
  assign q_item   = qmem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `MBEC_ASSERT(a_q_bound, count <= (mbec_pkg::QPTR_W+1)'(mbec_pkg::QDEPTH), "queue overfilled")
  `MBEC_ASSERT_NEXT(a_q_fill, push && !pop, count == $past(count) + 1'b1, "push lost")

endmodule
`default_nettype wire

// ===== src/mbec_back.sv =====
// Back end: per-channel read-modify-write of counters, stop checks, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "multichannel_bit_error_counter_macros.svh"
module mbec_back #(
  parameter int unsigned CHANNELS = mbec_pkg::DEF_CHANNELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [mbec_pkg::REG_W-1:0]  cfg_index,
  input  wire logic [mbec_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        q_valid,
  input  wire mbec_pkg::item_t             q_item,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mbec_pkg::CH_W-1:0]        chan_out,
  output logic [mbec_pkg::ERR_W-1:0]       error_count,
  output logic [mbec_pkg::CNT_W-1:0]       byte_total,
  output logic [mbec_pkg::ST_W-1:0]        status,
  output logic                             all_done
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FIN_W = $clog2(CHANNELS + 1);

  typedef enum logic [1:0] {B_IDLE, B_ADD, B_CHECK} state_t;

  state_t                          state;
  mbec_pkg::item_t                 cur;
  logic [mbec_pkg::ERR_W-1:0]      min_errors;
  logic [mbec_pkg::LIM_W-1:0]      bit_limit;
  logic [mbec_pkg::ERR_W-1:0]      err_mem  [CHANNELS];
  logic [mbec_pkg::CNT_W-1:0]      byte_mem [CHANNELS];
  logic [CHANNELS-1:0]             entry_valid;
  logic [CHANNELS-1:0]             stopped;
  logic [FIN_W-1:0]                finished;
  logic [mbec_pkg::ERR_W-1:0]      rd_err;
  logic [mbec_pkg::CNT_W-1:0]      rd_byte;
  logic                            rd_valid;
  logic                            rd_stopped;
  logic [mbec_pkg::ERR_W-1:0]      err_new;
  logic [mbec_pkg::CNT_W-1:0]      byte_new;
  logic                            was_stopped;
  logic [IDX_W+mbec_pkg::CH_W-1:0] head_wide;
  logic [IDX_W+mbec_pkg::CH_W-1:0] cur_wide;
  logic [IDX_W-1:0]                head_idx;
  logic [IDX_W-1:0]                cur_idx;
  logic [mbec_pkg::ERR_W-1:0]      err_old;
  logic [mbec_pkg::CNT_W-1:0]      byte_old;
  logic [mbec_pkg::ERR_W:0]        err_sum;
  logic                            adv;
  logic                            commit;
  logic                            hit_err;
  logic                            hit_lim;
  logic                            stop_hit;
  logic [FIN_W-1:0]                finished_next;

  assign head_wide = {IDX_W'(0), q_item.ch};
  assign cur_wide  = {IDX_W'(0), cur.ch};
  assign head_idx  = head_wide[IDX_W-1:0];
  assign cur_idx   = cur_wide[IDX_W-1:0];

  assign q_pop = (state == B_IDLE) && q_valid;

  // counters as read at pop time; untouched entries read as their reset value
  assign err_old  = rd_valid ? rd_err  : mbec_pkg::ERR_RST;
  assign byte_old = rd_valid ? rd_byte : '0;
  assign err_sum  = {1'b0, err_old} + (mbec_pkg::ERR_W+1)'(cur.add);

  assign adv      = (state == B_CHECK) && (!out_valid || out_ready);
  assign commit   = adv && cur.inrange && !was_stopped;
  assign hit_err  = (err_new >= min_errors);
  assign hit_lim  = (byte_new > (bit_limit >> 3));
  assign stop_hit = commit && (hit_err || hit_lim);
  assign finished_next = finished + FIN_W'(stop_hit);

  always_ff @(posedge clk) begin
    rd_err  <= err_mem[head_idx];
    rd_byte <= byte_mem[head_idx];
    if (commit) begin
      err_mem[cur_idx]  <= err_new;
      byte_mem[cur_idx] <= byte_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      out_valid   <= 1'b0;
      entry_valid <= '0;
      stopped     <= '0;
      finished    <= '0;
      min_errors  <= mbec_pkg::MIN_ERRORS_RST;
      bit_limit   <= mbec_pkg::BIT_LIMIT_RST;
      rd_valid    <= 1'b0;
      rd_stopped  <= 1'b0;
    end else begin
      rd_valid   <= entry_valid[head_idx];
      rd_stopped <= stopped[head_idx];
      if (cfg_we) begin
        case (cfg_index)
          mbec_pkg::REG_MIN_ERRORS: min_errors <= cfg_data[mbec_pkg::ERR_W-1:0];
          mbec_pkg::REG_BIT_LIMIT:  bit_limit  <= cfg_data[mbec_pkg::LIM_W-1:0];
          default: ;
        endcase
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= B_ADD;
          end
        end
        B_ADD: begin
          was_stopped <= rd_stopped;
          if (cur.inrange && !rd_stopped) begin
            err_new  <= err_sum[mbec_pkg::ERR_W] ? mbec_pkg::ERR_MAX
                                                 : err_sum[mbec_pkg::ERR_W-1:0];
            byte_new <= (byte_old == mbec_pkg::CNT_MAX) ? byte_old : byte_old + 1'b1;
          end else begin
            err_new  <= err_old;
            byte_new <= byte_old;
          end
          state <= B_CHECK;
        end
        B_CHECK: begin
          if (adv) begin
            chan_out  <= cur.ch;
            all_done  <= (32'(finished_next) >= CHANNELS);
            finished  <= finished_next;
            if (!cur.inrange) begin
              error_count <= '0;
              byte_total  <= '0;
              status      <= mbec_pkg::ST_IGNORED;
            end else if (was_stopped) begin
              error_count <= err_new;
              byte_total  <= byte_new;
              status      <= mbec_pkg::ST_IGNORED;
            end else begin
              error_count          <= err_new;
              byte_total           <= byte_new;
              entry_valid[cur_idx] <= 1'b1;
              if (hit_err) begin
                stopped[cur_idx] <= 1'b1;
                status           <= mbec_pkg::ST_ENOUGH;
              end else if (hit_lim) begin
                stopped[cur_idx] <= 1'b1;
                status           <= mbec_pkg::ST_LIMIT;
              end else begin
                status <= mbec_pkg::ST_COUNTED;
              end
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `MBEC_ASSERT(a_fin_bound, 32'(finished) <= CHANNELS, "finished count beyond channel count")
  `MBEC_ASSERT_NEXT(a_fin_hold, state != B_CHECK, $stable(finished), "finished count moved outside check")
  `MBEC_ASSERT(a_counted_bytes, !(out_valid && status != mbec_pkg::ST_IGNORED && byte_total == '0), "counted result with no bytes")
  `MBEC_ASSERT(a_oor_zero, !(out_valid && 32'(chan_out) >= CHANNELS && (error_count != '0 || byte_total != '0)), "out of range channel reported counts")

endmodule
`default_nettype wire

// ===== src/multichannel_bit_error_counter.sv =====
// Top level of the multichannel bit error counter.
`timescale 1ns / 1ps
`default_nettype none
// Counts bit errors between reference and received bytes on up to CHANNELS channels
// and stops each channel when it reaches min_errors or its bit count passes bit_limit.
// Each item yields one result. The front end takes an item in any cycle while its
// four-entry queue has room; the back end takes one item at a time through the idle, add
// and check states of its channel counter read-modify-write, stalling while out_ready
// is low; the queue absorbs bursts of up to four items. Counters of untouched channels
// read as their reset values through per-channel valid bits, so no clearing pass follows
// reset. Register writes apply to a channel at its next counted byte.
module multichannel_bit_error_counter #(
  parameter int unsigned CHANNELS = mbec_pkg::DEF_CHANNELS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [mbec_pkg::REG_W-1:0]  cfg_index,
  input  wire logic [mbec_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mbec_pkg::CH_W-1:0]   channel,
  input  wire logic [mbec_pkg::BYTE_W-1:0] ref_byte,
  input  wire logic [mbec_pkg::BYTE_W-1:0] rx_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [mbec_pkg::CH_W-1:0]        chan_out,
  output logic [mbec_pkg::ERR_W-1:0]       error_count,
  output logic [mbec_pkg::CNT_W-1:0]       byte_total,
  output logic [mbec_pkg::ST_W-1:0]        status,
  output logic                             all_done
);

  logic            q_valid;
  logic            q_pop;
  mbec_pkg::item_t q_item;

  mbec_front #(.CHANNELS(CHANNELS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .channel  (channel),
    .ref_byte (ref_byte),
    .rx_byte  (rx_byte),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mbec_back #(.CHANNELS(CHANNELS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .chan_out    (chan_out),
    .error_count (error_count),
    .byte_total  (byte_total),
    .status      (status),
    .all_done    (all_done)
  );

endmodule
`default_nettype wire
